// ----- hw/rtl/pcc_pkg.sv -----
package pcc_pkg;

    // default build values
    localparam int ITERATIONS_DEF  = 16;
    localparam int COORD_WIDTH_DEF = 16;

    // datapath widths: coordinates in Q.8, angle in 1/65536 degree
    localparam int DP_W   = 28;
    localparam int ANG_W  = 27;
    localparam int GAIN_W = 17;
    localparam int PROD_W = DP_W + GAIN_W;
    localparam int ATAN_LEN = 24;

    // inverse cordic gain, 0.6072529 in Q.16
    localparam logic signed [GAIN_W-1:0] CORDIC_K = 17'sd39797;

    localparam logic signed [ANG_W-1:0] DEG90  = 27'sd5898240;
    localparam logic signed [ANG_W-1:0] DEG180 = 27'sd11796480;
    localparam logic signed [ANG_W-1:0] DEG360 = 27'sd23592960;

    localparam logic signed [17:0] ANGLE_LIMIT = 18'sd23040;

    // atan(2^-i) in 1/65536 degree
    localparam logic signed [ANG_W-1:0] ATAN_TAB [0:ATAN_LEN-1] = '{
        27'sd2949120, 27'sd1740967, 27'sd919879, 27'sd466945,
        27'sd234379,  27'sd117304,  27'sd58666,  27'sd29335,
        27'sd14668,   27'sd7334,    27'sd3667,   27'sd1833,
        27'sd917,     27'sd458,     27'sd229,    27'sd115,
        27'sd57,      27'sd29,      27'sd14,     27'sd7,
        27'sd4,       27'sd2,       27'sd1,      27'sd0
    };

    typedef enum logic {
        OP_TO_POLAR = 1'b0,
        OP_TO_CART  = 1'b1
    } t_op;

    typedef struct packed {
        t_op                op;
        logic signed [15:0] x_in;
        logic signed [15:0] y_in;
        logic        [15:0] magnitude_in;
        logic signed [15:0] angle_in;
    } t_cmd;

    typedef struct packed {
        logic signed [15:0] x_out;
        logic signed [15:0] y_out;
        logic        [15:0] magnitude_out;
        logic signed [15:0] angle_out;
    } t_res;

    // one point on its way through the rotation stages
    typedef struct packed {
        t_op                    op;
        logic                   zero;
        logic signed [DP_W-1:0]  x;
        logic signed [DP_W-1:0]  y;
        logic signed [ANG_W-1:0] z;
    } t_lane;

endpackage

// ----- hw/rtl/pcc_stage.sv -----
module pcc_stage #(
    parameter int SHIFT = 0
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  pcc_pkg::t_lane i_lane,
    output logic          o_valid,
    output pcc_pkg::t_lane o_lane
);

    logic signed [pcc_pkg::DP_W-1:0]  w_x;
    logic signed [pcc_pkg::DP_W-1:0]  w_y;
    logic signed [pcc_pkg::ANG_W-1:0] w_z;
    logic signed [pcc_pkg::DP_W-1:0]  w_xs;
    logic signed [pcc_pkg::DP_W-1:0]  w_ys;
    logic                             w_ccw;
    pcc_pkg::t_lane                   n_lane;
    pcc_pkg::t_lane                   r_lane;
    logic                             r_valid;

    assign w_x  = i_lane.x;
    assign w_y  = i_lane.y;
    assign w_z  = i_lane.z;
    assign w_xs = w_x >>> SHIFT;
    assign w_ys = w_y >>> SHIFT;

    // rotation steers by the residual angle, vectoring by the sign of y
    assign w_ccw = (i_lane.op == pcc_pkg::OP_TO_CART) ? !w_z[pcc_pkg::ANG_W-1]
                                                      : w_y[pcc_pkg::DP_W-1];

    // one micro-rotation
    always_comb begin
        n_lane = i_lane;
        if (w_ccw) begin
            n_lane.x = w_x - w_ys;
            n_lane.y = w_y + w_xs;
            n_lane.z = w_z - pcc_pkg::ATAN_TAB[SHIFT];
        end else begin
            n_lane.x = w_x + w_ys;
            n_lane.y = w_y - w_xs;
            n_lane.z = w_z + pcc_pkg::ATAN_TAB[SHIFT];
        end
    end

    // valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    // stage payload
    always_ff @(posedge i_clk) begin
        r_lane <= n_lane;
    end

    assign o_valid = r_valid;
    assign o_lane  = r_lane;

endmodule

// ----- hw/rtl/polar_cartesian_converter_top.sv -----
// channel  | ports                 | handshake
// command  | start, busy, i_cmd    | beat taken when start is high and busy is low
// result   | o_done, o_res         | beat shown for one cycle while o_done is high
//
// a new command can be taken in every cycle; busy stays low
// the pipeline holds two set-up stages (angle wrap, quadrant fold), one registered
// stage per cordic step, a gain multiply and a round/saturate stage
// reset clears only the valid bits of the pipeline; payload registers are not reset
// the receiver cannot stall, so nothing ever waits inside the pipeline
module polar_cartesian_converter_top #(
    parameter int ITERATIONS  = pcc_pkg::ITERATIONS_DEF,
    parameter int COORD_WIDTH = pcc_pkg::COORD_WIDTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    input  pcc_pkg::t_cmd i_cmd,
    output logic          busy,
    output logic          o_done,
    output pcc_pkg::t_res o_res
);

    localparam int NSTEP = (ITERATIONS < pcc_pkg::ATAN_LEN) ? ITERATIONS : pcc_pkg::ATAN_LEN;
    localparam logic signed [33:0] SAT_HI = (34'sd1 <<< (COORD_WIDTH - 1)) - 34'sd1;
    localparam logic signed [33:0] SAT_LO = -SAT_HI - 34'sd1;

    localparam int DW = pcc_pkg::DP_W;
    localparam int AW = pcc_pkg::ANG_W;
    localparam int PW = pcc_pkg::PROD_W;

    // ---------------------------------------------------------------
    // stage 1: scale inputs, wrap the rotation angle
    // ---------------------------------------------------------------
    logic                  w_accept;
    logic signed [AW-1:0]  w_zin;
    pcc_pkg::t_lane        n_s1;
    pcc_pkg::t_lane        r_s1;
    logic                  r_s1_valid;

    assign busy     = 1'b0;
    assign w_accept = start && !busy;
    assign w_zin    = {{2{i_cmd.angle_in[15]}}, i_cmd.angle_in, 9'b0};

    always_comb begin
        n_s1.op   = i_cmd.op;
        n_s1.zero = (i_cmd.x_in == 16'sd0) && (i_cmd.y_in == 16'sd0);
        if (i_cmd.op == pcc_pkg::OP_TO_CART) begin
            n_s1.x = {{(DW-24){1'b0}}, i_cmd.magnitude_in, 8'b0};
            n_s1.y = '0;
            if (w_zin > pcc_pkg::DEG180) begin
                n_s1.z = w_zin - pcc_pkg::DEG360;
            end else if (w_zin < -pcc_pkg::DEG180) begin
                n_s1.z = w_zin + pcc_pkg::DEG360;
            end else begin
                n_s1.z = w_zin;
            end
        end else begin
            n_s1.x = {{(DW-24){i_cmd.x_in[15]}}, i_cmd.x_in, 8'b0};
            n_s1.y = {{(DW-24){i_cmd.y_in[15]}}, i_cmd.y_in, 8'b0};
            n_s1.z = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1 <= n_s1;
    end

    // ---------------------------------------------------------------
    // stage 2: fold into the right half plane
    // ---------------------------------------------------------------
    logic signed [DW-1:0] w_s1_x;
    logic signed [DW-1:0] w_s1_y;
    logic signed [AW-1:0] w_s1_z;
    pcc_pkg::t_lane       n_s2;
    pcc_pkg::t_lane       r_s2;
    logic                 r_s2_valid;

    pcc_pkg::t_lane       w_lane  [0:NSTEP];
    logic                 w_valid [0:NSTEP];

    assign w_s1_x = r_s1.x;
    assign w_s1_y = r_s1.y;
    assign w_s1_z = r_s1.z;

    always_comb begin
        n_s2 = r_s1;
        if (r_s1.op == pcc_pkg::OP_TO_CART) begin
            if (w_s1_z > pcc_pkg::DEG90) begin
                n_s2.x = '0;
                n_s2.y = w_s1_x;
                n_s2.z = w_s1_z - pcc_pkg::DEG90;
            end else if (w_s1_z < -pcc_pkg::DEG90) begin
                n_s2.x = '0;
                n_s2.y = -w_s1_x;
                n_s2.z = w_s1_z + pcc_pkg::DEG90;
            end
        end else if (w_s1_x[DW-1]) begin
            if (!w_s1_y[DW-1]) begin
                n_s2.x = w_s1_y;
                n_s2.y = -w_s1_x;
                n_s2.z = pcc_pkg::DEG90;
            end else begin
                n_s2.x = -w_s1_y;
                n_s2.y = w_s1_x;
                n_s2.z = -pcc_pkg::DEG90;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2 <= n_s2;
    end

    assign w_valid[0] = r_s2_valid;
    assign w_lane[0]  = r_s2;

    // ---------------------------------------------------------------
    // cordic steps, one registered stage each
    // ---------------------------------------------------------------
    for (genvar g = 0; g < NSTEP; g++) begin : g_step
        pcc_stage #(
            .SHIFT (g)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[g]),
            .i_lane  (w_lane[g]),
            .o_valid (w_valid[g+1]),
            .o_lane  (w_lane[g+1])
        );
    end

    // ---------------------------------------------------------------
    // gain correction multiply
    // ---------------------------------------------------------------
    logic signed [DW-1:0] w_cx;
    logic signed [DW-1:0] w_cy;
    logic signed [PW-1:0] n_px;
    logic signed [PW-1:0] n_py;
    logic signed [PW-1:0] r_px;
    logic signed [PW-1:0] r_py;
    logic signed [AW-1:0] r_pz;
    pcc_pkg::t_op         r_pop;
    logic                 r_pzero;
    logic                 r_pvalid;

    assign w_cx = w_lane[NSTEP].x;
    assign w_cy = w_lane[NSTEP].y;
    assign n_px = w_cx * pcc_pkg::CORDIC_K;
    assign n_py = w_cy * pcc_pkg::CORDIC_K;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pvalid <= 1'b0;
        end else begin
            r_pvalid <= w_valid[NSTEP];
        end
    end

    always_ff @(posedge i_clk) begin
        r_px    <= n_px;
        r_py    <= n_py;
        r_pz    <= w_lane[NSTEP].z;
        r_pop   <= w_lane[NSTEP].op;
        r_pzero <= w_lane[NSTEP].zero;
    end

    // ---------------------------------------------------------------
    // round, saturate and select the result fields
    // ---------------------------------------------------------------
    logic signed [PW-1:0] w_rx;
    logic signed [PW-1:0] w_ry;
    logic signed [AW-1:0] w_rz;
    logic signed [33:0]   w_ux;
    logic signed [33:0]   w_uy;
    logic signed [17:0]   w_ang;
    pcc_pkg::t_res        n_res;
    pcc_pkg::t_res        r_res;
    logic                 r_done;

    assign w_rx  = r_px + (PW'(1) <<< 23);
    assign w_ry  = r_py + (PW'(1) <<< 23);
    assign w_rz  = r_pz + AW'(256);
    assign w_ux  = 34'($signed(w_rx[PW-1:24]));
    assign w_uy  = 34'($signed(w_ry[PW-1:24]));
    assign w_ang = w_rz[AW-1:9];

    always_comb begin
        n_res = '0;
        if (r_pop == pcc_pkg::OP_TO_CART) begin
            if (w_ux > SAT_HI) begin
                n_res.x_out = SAT_HI[15:0];
            end else if (w_ux < SAT_LO) begin
                n_res.x_out = SAT_LO[15:0];
            end else begin
                n_res.x_out = w_ux[15:0];
            end
            if (w_uy > SAT_HI) begin
                n_res.y_out = SAT_HI[15:0];
            end else if (w_uy < SAT_LO) begin
                n_res.y_out = SAT_LO[15:0];
            end else begin
                n_res.y_out = w_uy[15:0];
            end
        end else if (!r_pzero) begin
            if (w_ux[33]) begin
                n_res.magnitude_out = '0;
            end else if (w_ux > 34'sd65535) begin
                n_res.magnitude_out = 16'hffff;
            end else begin
                n_res.magnitude_out = w_ux[15:0];
            end
            if (w_ang > pcc_pkg::ANGLE_LIMIT) begin
                n_res.angle_out = pcc_pkg::ANGLE_LIMIT[15:0];
            end else if (w_ang < -pcc_pkg::ANGLE_LIMIT) begin
                n_res.angle_out = -pcc_pkg::ANGLE_LIMIT[15:0];
            end else begin
                n_res.angle_out = w_ang[15:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_pvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule
